// ----- hw/rtl/ripemd128_hash_assert.svh -----
// Assertion macros for the RIPEMD-128 hash engine checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the scope of use.
`ifndef RIPEMD128_HASH_ASSERT_SVH
`define RIPEMD128_HASH_ASSERT_SVH

// same-cycle implication
`define RMD_CHECK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rmd128_pkg.sv -----
// Shared types, constants and round functions of the RIPEMD-128 hash engine.
// No dependencies.
`timescale 1ns / 1ps

package rmd128_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 2;
    localparam int BLK_WORDS = 16;
    localparam int STEPS     = 64;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_COMP = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic [3:0] LIDX [STEPS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2
    };

    localparam logic [3:0] LROT [STEPS] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12
    };

    localparam logic [3:0] RIDX [STEPS] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14
    };

    localparam logic [3:0] RROT [STEPS] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8
    };

    localparam logic [WORD_W-1:0] KL [4] = '{
        32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc
    };
    localparam logic [WORD_W-1:0] KR [4] = '{
        32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h00000000
    };
    localparam logic [WORD_W-1:0] IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [3:0] s);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << s;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] bool_fn(input logic [1:0] sel,
                                                  input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] y,
                                                  input logic [WORD_W-1:0] z);
        logic [WORD_W-1:0] f;
        case (sel)
            2'd0: f = x ^ y ^ z;
            2'd1: f = (x & y) | (~x & z);
            2'd2: f = (x | ~y) ^ z;
            default: f = (x & z) | (y & ~z);
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/rmd128_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rmd128_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/ripemd128_hash.sv -----
// RIPEMD-128 hash engine: block RAM, two-line round datapath; needs rmd128_pkg, rmd128_ram.
// Absorb beats take one byte each; a full block then stalls input through a load, 64 steps and
// a chain update. Finish: the same pass (twice when more than 55 bytes pend), then 4 digest
// beats, one per cycle without output stall.
// Synchronous active-low reset loads the initial chain and clears the counters; the block RAM
// is not cleared, a word fill count masks unwritten words.
`timescale 1ns / 1ps

module ripemd128_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_op,
    input  logic [rmd128_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                            o_stall,
    output logic                            o_valid,
    output logic [rmd128_pkg::WORD_W-1:0]   o_digest_word,
    output logic [rmd128_pkg::IDX_W-1:0]    o_word_index,
    output logic                            o_last_word,
    input  logic                            i_stall
);

    import rmd128_pkg::*;

    t_state              r_state, n_state;
    logic [5:0]          r_step;
    logic [63:0]         r_cnt;
    logic [WORD_W-1:0]   r_acc;
    logic [4:0]          r_fill;
    logic                r_final;
    logic                r_fin_pend;
    logic [IDX_W-1:0]    r_oidx;
    logic [WORD_W-1:0]   r_chain [4];
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d;
    logic [WORD_W-1:0]   r_a2, r_b2, r_c2, r_d2;

    logic                in_acc;
    logic [5:0]          pos;
    logic [WORD_W-1:0]   byte_sh, pad_sh, wdata;
    logic                we;
    logic [5:0]          nstep;
    logic [WORD_W-1:0]   rdata_a, rdata_b;
    logic [63:0]         bitlen;
    logic [3:0]          l_idx, r_idx;
    logic [WORD_W-1:0]   xl, xr, tl, tr;
    logic [1:0]          rnd;

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign pos     = r_cnt[5:0];
    assign byte_sh = {{(WORD_W-BYTE_W){1'b0}}, i_data_byte} << {pos[1:0], 3'b000};
    assign pad_sh  = {{(WORD_W-BYTE_W){1'b0}}, 8'h80} << {pos[1:0], 3'b000};
    assign wdata   = r_acc | (i_op ? pad_sh : byte_sh);
    assign we      = in_acc && (i_op || (pos[1:0] == 2'd3));
    assign nstep   = (r_state == S_COMP) ? r_step + 6'd1 : 6'd0;
    assign bitlen  = {r_cnt[60:0], 3'b000};

    rmd128_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_blk (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (pos[5:2]),
        .i_wdata   (wdata),
        .i_raddr_a (LIDX[nstep]),
        .i_raddr_b (RIDX[nstep]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    function automatic logic [WORD_W-1:0] blk_word(input logic [3:0] idx,
                                                   input logic [WORD_W-1:0] rd,
                                                   input logic fin,
                                                   input logic [4:0] fill,
                                                   input logic [63:0] len);
        logic [WORD_W-1:0] v;
        if (fin && (idx == 4'd14)) begin
            v = len[31:0];
        end else if (fin && (idx == 4'd15)) begin
            v = len[63:32];
        end else if ({1'b0, idx} < fill) begin
            v = rd;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign l_idx = LIDX[r_step];
    assign r_idx = RIDX[r_step];
    assign rnd   = r_step[5:4];
    assign xl    = blk_word(l_idx, rdata_a, r_final, r_fill, bitlen);
    assign xr    = blk_word(r_idx, rdata_b, r_final, r_fill, bitlen);
    assign tl    = rotl32(r_a + bool_fn(rnd, r_b, r_c, r_d) + xl + KL[rnd], LROT[r_step]);
    assign tr    = rotl32(r_a2 + bool_fn(~rnd, r_b2, r_c2, r_d2) + xr + KR[rnd],
                          RROT[r_step]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && (i_op || (pos == 6'd63))) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_COMP;
            S_COMP: begin
                if (r_step == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_final) begin
                    n_state = S_OUT;
                end else if (r_fin_pend) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stall && (r_oidx == 2'd3)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_fill     <= '0;
            r_final    <= 1'b0;
            r_fin_pend <= 1'b0;
            r_oidx     <= '0;
            r_chain    <= IV;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_op) begin
                            r_cnt <= r_cnt + 64'd1;
                            if (pos[1:0] == 2'd3) begin
                                r_acc  <= '0;
                                r_fill <= {1'b0, pos[5:2]} + 5'd1;
                            end else begin
                                r_acc <= wdata;
                            end
                            r_final    <= 1'b0;
                            r_fin_pend <= 1'b0;
                        end else begin
                            r_acc      <= '0;
                            r_fill     <= {1'b0, pos[5:2]} + 5'd1;
                            r_final    <= (pos <= 6'd55);
                            r_fin_pend <= 1'b1;
                        end
                    end
                end
                S_LOAD: begin
                    r_step <= '0;
                    r_a    <= r_chain[0];
                    r_b    <= r_chain[1];
                    r_c    <= r_chain[2];
                    r_d    <= r_chain[3];
                    r_a2   <= r_chain[0];
                    r_b2   <= r_chain[1];
                    r_c2   <= r_chain[2];
                    r_d2   <= r_chain[3];
                end
                S_COMP: begin
                    r_step <= r_step + 6'd1;
                    r_a    <= r_d;
                    r_d    <= r_c;
                    r_c    <= r_b;
                    r_b    <= tl;
                    r_a2   <= r_d2;
                    r_d2   <= r_c2;
                    r_c2   <= r_b2;
                    r_b2   <= tr;
                end
                S_FIN: begin
                    r_chain[0] <= r_chain[1] + r_c + r_d2;
                    r_chain[1] <= r_chain[2] + r_d + r_a2;
                    r_chain[2] <= r_chain[3] + r_a + r_b2;
                    r_chain[3] <= r_chain[0] + r_b + r_c2;
                    r_fill     <= '0;
                    r_oidx     <= '0;
                    if (!r_final && r_fin_pend) begin
                        r_final <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_chain    <= IV;
                            r_cnt      <= '0;
                            r_acc      <= '0;
                            r_fill     <= '0;
                            r_final    <= 1'b0;
                            r_fin_pend <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

endmodule

// ----- hw/rtl/rmd128_check.sv -----
// Port-level checker for the RIPEMD-128 hash engine, bound to its top level.
// Depends on rmd128_pkg and ripemd128_hash_assert.svh.
`timescale 1ns / 1ps
`include "ripemd128_hash_assert.svh"

module rmd128_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            i_op,
    input logic [rmd128_pkg::BYTE_W-1:0]   i_data_byte,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic [rmd128_pkg::WORD_W-1:0]   o_digest_word,
    input logic [rmd128_pkg::IDX_W-1:0]    o_word_index,
    input logic                            o_last_word,
    input logic                            i_stall
);

    import rmd128_pkg::*;

    `RMD_CHECK_SAME(a_last_idx, o_valid && o_last_word, o_word_index == 2'd3, "last beat off index")
    `RMD_CHECK_NEXT(a_burst, o_valid && !i_stall && !o_last_word, o_valid, "digest burst broken")
    `RMD_CHECK_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_digest_word) && $stable(o_word_index), "stalled beat changed")
    `RMD_CHECK_SAME(a_busy_out, o_valid, o_stall, "input taken during digest")
    `RMD_CHECK_NEXT(a_absorb_quiet, i_valid && !o_stall && !i_op, !o_valid, "absorb beat gave output")

endmodule

bind ripemd128_hash rmd128_check u_check (.*);

// ----- dv/ripemd128_hash_tb.sv -----
// Self-checking testbench for the RIPEMD-128 hash engine: byte beats in, digest words out.
// Uses a scoreboard class with its own RIPEMD-128 model and queue of expected digest words.
// Depends on rmd128_pkg and the ripemd128_hash RTL.
`timescale 1ns / 1ps

typedef enum bit {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
} hash_op_e;

typedef struct {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
} digest_beat_t;

class digest_scoreboard;
    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [63:0]  nbytes;
    digest_beat_t expected_digest_words [$];
    int           errors;
    int unsigned  l_idx [64];
    int unsigned  l_rot [64];
    int unsigned  r_idx [64];
    int unsigned  r_rot [64];
    logic [31:0]  l_k [4];
    logic [31:0]  r_k [4];
    logic [31:0]  init_chain [4];

    function new();
        l_idx = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                  7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
                  3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
                  1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2};
        l_rot = '{11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
                  7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
                  11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
                  11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12};
        r_idx = '{5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
                  6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
                  15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
                  8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14};
        r_rot = '{8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
                  9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
                  9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
                  15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8};
        l_k = '{32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc};
        r_k = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h00000000};
        init_chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain = init_chain;
        foreach (blk[i]) blk[i] = 32'h0;
        nbytes = 64'h0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function logic [31:0] mix(int unsigned sel, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
        case (sel)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            default: return (x & z) | (y & ~z);
        endcase
    endfunction

    function void compress();
        logic [31:0] al, bl, cl, dl, ar, br, cr, dr, t;
        int unsigned rnd;
        al = chain[0]; bl = chain[1]; cl = chain[2]; dl = chain[3];
        ar = al; br = bl; cr = cl; dr = dl;
        for (int j = 0; j < 64; j++) begin
            rnd = j / 16;
            t = rol(al + mix(rnd, bl, cl, dl) + blk[l_idx[j]] + l_k[rnd], l_rot[j]);
            al = dl; dl = cl; cl = bl; bl = t;
            t = rol(ar + mix(3 - rnd, br, cr, dr) + blk[r_idx[j]] + r_k[rnd], r_rot[j]);
            ar = dr; dr = cr; cr = br; br = t;
        end
        t = chain[1] + cl + dr;
        chain[1] = chain[2] + dl + ar;
        chain[2] = chain[3] + al + br;
        chain[3] = chain[0] + bl + cr;
        chain[0] = t;
    endfunction

    function void compress_and_clear();
        compress();
        foreach (blk[i]) blk[i] = 32'h0;
    endfunction

    function void put_byte(logic [5:0] pos, logic [7:0] b);
        blk[pos[5:2]] |= 32'(b) << (8 * pos[1:0]);
    endfunction

    function void note_beat(hash_op_e op, logic [7:0] b);
        logic [5:0]   pos;
        logic [63:0]  nbits;
        digest_beat_t e;
        pos = nbytes[5:0];
        if (op == OP_ABSORB) begin
            put_byte(pos, b);
            nbytes++;
            if (pos == 6'd63) compress_and_clear();
        end else begin
            put_byte(pos, 8'h80);
            if (pos > 6'd55) compress_and_clear();
            nbits = nbytes << 3;
            blk[14] = nbits[31:0];
            blk[15] = nbits[63:32];
            compress();
            for (int k = 0; k < 4; k++) begin
                e.word = chain[k];
                e.idx  = 2'(k);
                e.last = (k == 3);
                expected_digest_words.push_back(e);
            end
            restart();
        end
    endfunction

    function int pending();
        return expected_digest_words.size();
    endfunction

    task report(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task check_beat(logic [31:0] word, logic [1:0] idx, logic last);
        digest_beat_t e;
        if (expected_digest_words.size() == 0) begin
            report($sformatf("digest beat %h idx %0d last %0d with none expected",
                             word, idx, last));
        end else begin
            e = expected_digest_words.pop_front();
            if (word !== e.word || idx !== e.idx || last !== e.last)
                report($sformatf("got word %h idx %0d last %0d, want %h idx %0d last %0d",
                                 word, idx, last, e.word, e.idx, e.last));
        end
    endtask
endclass

module ripemd128_hash_tb;

    localparam int unsigned LIMIT = 400000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          DRAIN_CYCLES = 150;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              i_op = OP_ABSORB;
    logic [rmd128_pkg::BYTE_W-1:0]     i_data_byte = '0;
    logic                              o_stall;
    logic                              o_valid;
    logic [rmd128_pkg::WORD_W-1:0]     o_digest_word;
    logic [rmd128_pkg::IDX_W-1:0]      o_word_index;
    logic                              o_last_word;
    logic                              i_stall = 1'b0;

    digest_scoreboard sb = new();
    int unsigned      cycles = 0;
    int               n_sent = 0;
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;

    ripemd128_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .i_stall       (i_stall)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 10);
        if (r < 85) return $urandom_range(11, 32);
        return $urandom_range(48, 70);
    endfunction

    task automatic send_beat(input hash_op_e op, input logic [7:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_beat(op, b);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(input int len);
        for (int i = 0; i < len; i++)
            send_beat(OP_ABSORB, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // receive side: check each digest beat, then pick the next stall
    initial begin
        int run;
        int hold_left;
        run = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_beat(o_digest_word, o_word_index, o_last_word);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (run > 0) begin
                run--;
                i_stall <= 1'b1;
            end else begin
                run = pick_gap();
                i_stall <= (run > 0);
                if (run > 0) run--;
            end
        end
    end

    initial begin
        int forced_len [3];
        int msgs;
        int len;
        forced_len = '{55, 63, 64};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, data ignored on finish
        send_beat(OP_FINISH, 8'hff);
        send_beat(OP_ABSORB, 8'h61);
        send_beat(OP_ABSORB, 8'h62);
        send_beat(OP_ABSORB, 8'h63);
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_ABSORB, 8'h00);
        send_beat(OP_ABSORB, 8'hff);
        send_beat(OP_ABSORB, 8'h80);
        send_beat(OP_ABSORB, 8'h01);
        send_beat(OP_ABSORB, 8'h7f);
        send_beat(OP_FINISH, 8'h55);
        send_beat(OP_ABSORB, 8'hff);
        send_beat(OP_FINISH, 8'haa);
        send_beat(OP_ABSORB, 8'h00);
        send_beat(OP_FINISH, 8'h00);
        quiet = 1'b1;
        send_beat(OP_ABSORB, 8'ha5);
        send_beat(OP_ABSORB, 8'h5a);
        send_beat(OP_ABSORB, 8'hc3);
        send_beat(OP_ABSORB, 8'h3c);
        send_beat(OP_FINISH, 8'hff);
        quiet = 1'b0;

        msgs = 0;
        while (n_sent < 180 || msgs < 3) begin
            len = (msgs < 3) ? forced_len[msgs] : pick_len();
            quiet = (msgs % 4 == 3);
            send_bytes(len);
            // hold the receiver after the first message, so its digest stalls and the next message waits
            if (msgs == 0) hold_req = 1'b1;
            send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
            if (msgs == 1) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            msgs++;
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rmd128_pkg.sv
hw/rtl/rmd128_ram.sv
hw/rtl/ripemd128_hash.sv
hw/rtl/rmd128_check.sv
dv/ripemd128_hash_tb.sv
